// File: sv/bsfe_pkg.sv
// Shared types and constants for the bit stuffing frame encoder.
// No dependencies; imported by every module of the block.
package bsfe_pkg;

    localparam int CMD_BITS = 11;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [2:0] STUFF_RUN = 3'd5;

    localparam logic [3:0] LEN_START = 4'd11;
    localparam logic [3:0] LEN_END   = 4'd8;
    localparam logic [3:0] LEN_STUFF = 4'd2;
    localparam logic [3:0] LEN_DATA  = 4'd1;

    // One classified item: bits left aligned, sent MSB first, len of them.
    typedef struct packed {
        logic [CMD_BITS-1:0] bits;
        logic [3:0]          len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: sv/bsfe_front.sv
// Front end: accepts input transactions, tracks the run of payload 1s and
// turns each item into a serial command. Depends on bsfe_pkg.
module bsfe_front import bsfe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic       s_data_bit,
    input  logic [2:0] s_dest_address,
    input  q_stat_t    q_stat,
    output logic       push,
    output cmd_t       push_cmd
);

    logic [2:0] ones_run_reg;
    logic [2:0] ones_run_next;
    logic       cmd_valid;
    logic       accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && cmd_valid;

    always_comb begin
        cmd_valid     = 1'b1;
        push_cmd.bits = '0;
        push_cmd.len  = LEN_DATA;
        ones_run_next = ones_run_reg;
        case (s_kind)
            KIND_START: begin
                push_cmd.bits = {FLAG_BYTE, s_dest_address};
                push_cmd.len  = LEN_START;
                ones_run_next = '0;
            end
            KIND_DATA: begin
                if (s_data_bit) begin
                    push_cmd.bits = {1'b1, {(CMD_BITS-1){1'b0}}};
                    if (ones_run_reg == STUFF_RUN - 3'd1) begin
                        // fifth 1 in a row: append the stuffed 0
                        push_cmd.len  = LEN_STUFF;
                        ones_run_next = '0;
                    end else begin
                        ones_run_next = ones_run_reg + 3'd1;
                    end
                end else begin
                    ones_run_next = '0;
                end
            end
            KIND_END: begin
                push_cmd.bits = {FLAG_BYTE, 3'b000};
                push_cmd.len  = LEN_END;
                ones_run_next = '0;
            end
            default: begin
                // unused kind: drop, state unchanged
                cmd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ones_run_reg <= '0;
        end else if (accept) begin
            ones_run_reg <= ones_run_next;
        end
    end

    a_run_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        ones_run_reg < STUFF_RUN)
        else $error("ones run reached stuffing limit without clearing");

endmodule

// File: sv/bsfe_queue.sv
// Two-entry command queue between front and back end.
// Depends on bsfe_pkg.
module bsfe_queue import bsfe_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    pop_cmd,
    output q_stat_t q_stat
);

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign do_pop       = pop && !q_stat.empty;
    assign pop_cmd      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_stat.full))
        else $error("push into full queue");

endmodule

// File: sv/bsfe_back.sv
// Back end: shifts queued commands out one line bit per transaction and
// flags the last bit of each. Depends on bsfe_pkg.
module bsfe_back import bsfe_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cmd_t    pop_cmd,
    input  q_stat_t q_stat,
    output logic    pop,
    output logic    m_valid,
    input  logic    m_ready,
    output logic    m_line_bit,
    output logic    m_run_last
);

    logic [CMD_BITS-1:0] bits_reg;
    logic [3:0]          len_reg;
    logic                take;
    logic                load;

    assign m_valid    = (len_reg != 4'd0);
    assign m_line_bit = bits_reg[CMD_BITS-1];
    assign m_run_last = (len_reg == 4'd1);

    assign take = m_valid && m_ready;
    // refill on the cycle the last bit leaves so a queued command has no gap
    assign load = !q_stat.empty && (!m_valid || (take && m_run_last));
    assign pop  = load;

    always_ff @(posedge aclk) begin
        if (load) begin
            bits_reg <= pop_cmd.bits;
        end else if (take) begin
            bits_reg <= {bits_reg[CMD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (load) begin
            len_reg <= pop_cmd.len;
        end else if (take) begin
            len_reg <= len_reg - 4'd1;
        end
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_START)
        else $error("bit count exceeds longest command");

    a_load_on_gap_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !pop)
        else $error("command popped while a bit is stalled");

endmodule

// File: sv/bit_stuffing_frame_encoder.sv
// Top level of the bit stuffing frame encoder: front end, command queue,
// back end. Depends on bsfe_pkg, bsfe_front, bsfe_queue, bsfe_back.
//
//  channel | direction | payload                          | handshake
//  s_      | in        | kind, data_bit, dest_address     | s_valid / s_ready
//  m_      | out       | line_bit, run_last               | m_valid / m_ready
//
// An item is classified in the cycle it is accepted; the back end's shift
// register sends one line bit per cycle while m_ready is high: 1 for a data
// item, 2 with a stuffed 0, 8 for an end flag, 11 for a start flag plus
// address. s_ready drops only when the two-entry command queue is full.
// Synchronous active-low reset clears the run count, queue and bit count.
module bit_stuffing_frame_encoder import bsfe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic       s_data_bit,
    input  logic [2:0] s_dest_address,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_line_bit,
    output logic       m_run_last
);

    q_stat_t q_stat;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    pop_cmd;

    bsfe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_data_bit     (s_data_bit),
        .s_dest_address (s_dest_address),
        .q_stat         (q_stat),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    bsfe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    bsfe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_cmd    (pop_cmd),
        .q_stat     (q_stat),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_line_bit (m_line_bit),
        .m_run_last (m_run_last)
    );

endmodule

// File: tb/sv/tb_bit_stuffing_frame_encoder.sv
// Testbench for bit_stuffing_frame_encoder: random valid/ready traffic on both sides,
// line bits checked in order against a bit-level frame predictor held in a scoreboard.
// Depends on bsfe_pkg and the bit_stuffing_frame_encoder RTL.

class frame_scoreboard;
    typedef struct packed {
        logic line_bit;
        logic run_last;
    } line_bit_t;

    line_bit_t  line_q[$];
    logic [2:0] ones_run;
    int         errors;

    function new();
        ones_run = '0;
        errors   = 0;
    endfunction

    // Queue len bits of pattern, MSB first, marking the final one.
    function void push_bits(logic [10:0] pattern, int len);
        line_bit_t b;
        for (int i = len - 1; i >= 0; i--) begin
            b.line_bit = pattern[i];
            b.run_last = (i == 0);
            line_q = {line_q, b};
        end
    endfunction

    function void note_item(logic [1:0] kind, logic data_bit, logic [2:0] addr);
        case (kind)
            bsfe_pkg::KIND_START: begin
                push_bits({bsfe_pkg::FLAG_BYTE, addr}, 11);
                ones_run = '0;
            end
            bsfe_pkg::KIND_DATA: begin
                if (data_bit) begin
                    ones_run = ones_run + 3'd1;
                    if (ones_run >= bsfe_pkg::STUFF_RUN) begin
                        // Insert the stuffed zero right after the fifth one.
                        push_bits(11'b10, 2);
                        ones_run = '0;
                    end else begin
                        push_bits(11'b1, 1);
                    end
                end else begin
                    push_bits(11'b0, 1);
                    ones_run = '0;
                end
            end
            bsfe_pkg::KIND_END: begin
                push_bits({3'b000, bsfe_pkg::FLAG_BYTE}, 8);
                ones_run = '0;
            end
            default: ;  // unused kind: drop without effect
        endcase
    endfunction

    function void check_bit(logic line_bit, logic run_last);
        line_bit_t want;
        if (line_q.size() == 0) begin
            $error("unexpected line bit: line_bit=%0b run_last=%0b", line_bit, run_last);
            errors++;
            return;
        end
        want = line_q[0];
        line_q.delete(0);
        if (line_bit !== want.line_bit) begin
            $error("line_bit mismatch: expected %0b, actual %0b", want.line_bit, line_bit);
            errors++;
        end
        if (run_last !== want.run_last) begin
            $error("run_last mismatch: expected %0b, actual %0b", want.run_last, run_last);
            errors++;
        end
    endfunction

    function int pending();
        return line_q.size();
    endfunction
endclass

module tb_bit_stuffing_frame_encoder;
    import bsfe_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 180;
    localparam int IDLE_LIMIT    = 3000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind = '0;
    logic       s_data_bit = 1'b0;
    logic [2:0] s_dest_address = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_line_bit;
    logic       m_run_last;

    frame_scoreboard sb = new();
    bit steady_phase = 1'b0;
    int sent_items = 0;
    int idle_cycles = 0;

    bit_stuffing_frame_encoder DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_data_bit     (s_data_bit),
        .s_dest_address (s_dest_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_bit     (m_line_bit),
        .m_run_last     (m_run_last)
    );

    always #4 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [1:0] kind, logic data_bit, logic [2:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) begin
                s_kind         = 2'($urandom_range(0, 3));
                s_data_bit     = 1'($urandom_range(0, 1));
                s_dest_address = 3'($urandom_range(0, 7));
                @(negedge aclk);
            end
        end
        s_kind         = kind;
        s_data_bit     = data_bit;
        s_dest_address = addr;
        s_valid        = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(kind, data_bit, addr);
        if (kind != KIND_UNUSED) sent_items++;
        @(negedge aclk);
    endtask

    // Hold the sender off until every queued line bit has come out.
    task automatic drain_results();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic send_data(logic data_bit);
        send_item(KIND_DATA, data_bit, 3'($urandom_range(0, 7)));
    endtask

    task automatic send_start(logic [2:0] addr);
        send_item(KIND_START, 1'($urandom_range(0, 1)), addr);
    endtask

    task automatic send_end();
        send_item(KIND_END, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    endtask

    task automatic run_directed();
        // Payload with no open frame, stuffed on the fifth one.
        repeat (5) send_data(1'b1);
        // Address ones must not count toward the run.
        send_start(3'd7);
        repeat (4) send_data(1'b1);
        send_data(1'b0);
        repeat (2) send_data(1'b1);
        // Unused kind in mid-run must leave the count alone.
        send_item(KIND_UNUSED, 1'b1, 3'd7);
        repeat (3) send_data(1'b1);
        repeat (2) send_data(1'b1);
        // End flag clears the run: the next stuff comes after five more ones.
        send_end();
        repeat (5) send_data(1'b1);
        send_start(3'd0);
        send_end();
    endtask

    task automatic run_random();
        int len;
        bit ones_heavy;
        while (sent_items < RANDOM_ITEMS) begin
            steady_phase = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                len        = $urandom_range(0, 14);
                ones_heavy = 1'($urandom_range(0, 1));
                send_start(3'($urandom_range(0, 7)));
                repeat (len) begin
                    if (ones_heavy) send_data($urandom_range(0, 3) != 0);
                    else send_data(1'($urandom_range(0, 1)));
                end
                send_end();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              3'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 9) == 0) drain_results();
        end
        steady_phase = 1'b0;
    endtask

    // Receiver back-pressure: random stalls between bursts of ready.
    initial begin
        int gap;
        repeat (6) @(negedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_bit(m_line_bit, m_run_last);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_bit_stuffing_frame_encoder: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        run_directed();
        drain_results();
        run_random();
        drain_results();
        repeat (16) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_bit_stuffing_frame_encoder: PASS");
        end else begin
            $display("tb_bit_stuffing_frame_encoder: FAIL");
        end
        $finish;
    end
endmodule

// File: filelist.f
sv/bsfe_pkg.sv
sv/bsfe_front.sv
sv/bsfe_queue.sv
sv/bsfe_back.sv
sv/bit_stuffing_frame_encoder.sv
tb/sv/tb_bit_stuffing_frame_encoder.sv
